[hdl/lbt_pkg.sv]
// lbt_pkg: field widths, reset constants, register indexes and types for
// the lane blob tracker. No dependencies.
package lbt_pkg;

  localparam int XW = 14;   // column, 1/16 pixel
  localparam int YW = 11;   // row, 1/16 pixel
  localparam int AW = 16;   // blob pixel count
  localparam int EW = 16;   // steering error
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // Geometry of the camera region, fixed point with FracBits fraction bits
  localparam int ImageWidth   = 640;
  localparam int RegionHeight = 90;
  localparam int FracBits     = 4;

  localparam logic [XW-1:0] LEFT_X0  = XW'((ImageWidth / 2) << FracBits);
  localparam logic [XW-1:0] RIGHT_X0 = XW'(450 << FracBits);
  localparam logic [YW-1:0] ROW_Y0   = YW'((RegionHeight / 2) << FracBits);

  localparam logic [AW-1:0] MIN_AREA_RST = AW'(100);
  localparam logic [XW-1:0] GATE_X_RST   = XW'(150 << FracBits);
  localparam logic [YW-1:0] GATE_Y_RST   = YW'(50 << FracBits);
  localparam logic [XW-1:0] JUMP_X_RST   = XW'(200 << FracBits);
  localparam logic [YW-1:0] JUMP_Y_RST   = YW'(60 << FracBits);

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_MIN_AREA = 3'd0;
  localparam logic [CFG_IW-1:0] REG_GATE_X   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GATE_Y   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_JUMP_X   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_JUMP_Y   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CENTER_X = 3'd5;

  localparam int NUM_LANES = 2;
  localparam int LANE_LEFT  = 0;
  localparam int LANE_RIGHT = 1;

  typedef struct packed {
    logic [XW-1:0] centroid_x;
    logic [YW-1:0] centroid_y;
    logic [AW-1:0] area;
    logic          first_blob;
    logic          last_blob;
  } blob_t;

  typedef struct packed {
    logic [XW-1:0] tx;
    logic [YW-1:0] ty;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [XW-1:0] bdx;
    logic [YW-1:0] bdy;
  } lane_t;

  function automatic lane_t lane_init(input logic [XW-1:0] x0);
    lane_t l;
    l.tx  = x0;
    l.ty  = ROW_Y0;
    l.cx  = x0;
    l.cy  = ROW_Y0;
    l.bdx = '0;
    l.bdy = '0;
    return l;
  endfunction

  function automatic logic [XW-1:0] absdiff_x(input logic [XW-1:0] a,
                                              input logic [XW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [YW-1:0] absdiff_y(input logic [YW-1:0] a,
                                              input logic [YW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

[hdl/lbt_in_if.sv]
// lbt_in_if: blob input channel, valid/ready with blob fields.
// Depends on lbt_pkg for field widths.
interface lbt_in_if;
  logic                    valid;
  logic                    ready;
  logic [lbt_pkg::XW-1:0]  centroid_x;
  logic [lbt_pkg::YW-1:0]  centroid_y;
  logic [lbt_pkg::AW-1:0]  area;
  logic                    first_blob;
  logic                    last_blob;

  modport source (output valid, centroid_x, centroid_y, area, first_blob, last_blob,
                  input ready);
  modport sink   (input valid, centroid_x, centroid_y, area, first_blob, last_blob,
                  output ready);
endinterface

[hdl/lbt_out_if.sv]
// lbt_out_if: track result channel, valid/ready with track and steering fields.
// Depends on lbt_pkg for field widths.
interface lbt_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbt_pkg::XW-1:0]        left_x;
  logic [lbt_pkg::YW-1:0]        left_y;
  logic [lbt_pkg::XW-1:0]        right_x;
  logic [lbt_pkg::YW-1:0]        right_y;
  logic signed [lbt_pkg::EW-1:0] steer_error;

  modport source (output valid, left_x, left_y, right_x, right_y, steer_error,
                  input ready);
  modport sink   (input valid, left_x, left_y, right_x, right_y, steer_error,
                  output ready);
endinterface

[hdl/lane_blob_tracker.sv]
// lane_blob_tracker: top level, left/right lane line tracking from blobs.
// Depends on lbt_pkg, lbt_in_if and lbt_out_if.
//
// Usage:
//  - in_blob carries one labelled blob per beat: centroid (1/16 pixel),
//    area and first/last-of-frame marks. A beat moves on valid && ready.
//  - out_trk carries one beat per frame, on the blob marked last: both
//    tracks after the end-of-frame update and the steering error
//    2*image_center_x - left_x - right_x (1/16 pixel, two's complement).
//  - cfg_* writes one register per cycle when cfg_we is high; indexes 0..5
//    are min_area, gate_x, gate_y, jump_x, jump_y, image_center_x, others
//    are dropped. Write only while no blob is in flight.
// Timing:
//  - Two register stages: the accepted blob lands in the input register,
//    the lane compare/update logic runs from there and commits the track
//    state and, on a last blob, the output register.
//  - Throughput is one blob per cycle while no last blob waits on out_trk;
//    each blob that moves on rewrites the track state the next one sees.
//  - When out_trk stalls, blobs that are not last keep flowing; a last
//    blob waits in the input register until the output register frees.
// Reset (rst_n low, synchronous): registers to their defaults, tracks and
// candidates to the start positions, best distances to zero, no beats held.
module lane_blob_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  lbt_in_if.sink                        in_blob,
  lbt_out_if.source                     out_trk,
  input  logic                          cfg_we,
  input  logic [lbt_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [lbt_pkg::CFG_DW-1:0]    cfg_data
);

  // ---------------- configuration registers ----------------
  logic [lbt_pkg::AW-1:0] min_area_r;
  logic [lbt_pkg::XW-1:0] gate_x_r;
  logic [lbt_pkg::YW-1:0] gate_y_r;
  logic [lbt_pkg::XW-1:0] jump_x_r;
  logic [lbt_pkg::YW-1:0] jump_y_r;
  logic [lbt_pkg::XW-1:0] center_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_area_r <= lbt_pkg::MIN_AREA_RST;
      gate_x_r   <= lbt_pkg::GATE_X_RST;
      gate_y_r   <= lbt_pkg::GATE_Y_RST;
      jump_x_r   <= lbt_pkg::JUMP_X_RST;
      jump_y_r   <= lbt_pkg::JUMP_Y_RST;
      center_x_r <= lbt_pkg::LEFT_X0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbt_pkg::REG_MIN_AREA: min_area_r <= cfg_data[lbt_pkg::AW-1:0];
        lbt_pkg::REG_GATE_X:   gate_x_r   <= cfg_data[lbt_pkg::XW-1:0];
        lbt_pkg::REG_GATE_Y:   gate_y_r   <= cfg_data[lbt_pkg::YW-1:0];
        lbt_pkg::REG_JUMP_X:   jump_x_r   <= cfg_data[lbt_pkg::XW-1:0];
        lbt_pkg::REG_JUMP_Y:   jump_y_r   <= cfg_data[lbt_pkg::YW-1:0];
        lbt_pkg::REG_CENTER_X: center_x_r <= cfg_data[lbt_pkg::XW-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  lbt_pkg::blob_t blob_r;
  logic           blob_vld_r;
  logic           out_vld_r;
  logic           out_free;
  logic           blob_go;   // input register commits this cycle
  logic           in_fire;

  assign out_free = !out_vld_r || out_trk.ready;
  // a non-last blob never needs the output slot
  assign blob_go  = blob_vld_r && (!blob_r.last_blob || out_free);
  assign in_blob.ready = !blob_vld_r || blob_go;
  assign in_fire  = in_blob.valid && in_blob.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blob_vld_r <= 1'b0;
    end else if (in_blob.ready) begin
      blob_vld_r <= in_blob.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      blob_r.centroid_x <= in_blob.centroid_x;
      blob_r.centroid_y <= in_blob.centroid_y;
      blob_r.area       <= in_blob.area;
      blob_r.first_blob <= in_blob.first_blob;
      blob_r.last_blob  <= in_blob.last_blob;
    end
  end

  // ---------------- lane logic ----------------
  lbt_pkg::lane_t lane_r   [lbt_pkg::NUM_LANES];
  lbt_pkg::lane_t lane_nxt [lbt_pkg::NUM_LANES];
  logic           big;

  assign big = blob_r.area > min_area_r;

  for (genvar k = 0; k < lbt_pkg::NUM_LANES; k++) begin : g_lane
    logic [lbt_pkg::XW-1:0] dx, bdx_cur, jx;
    logic [lbt_pkg::YW-1:0] dy, bdy_cur, jy;
    logic                   take;

    always_comb begin
      dx = lbt_pkg::absdiff_x(lane_r[k].tx, blob_r.centroid_x);
      dy = lbt_pkg::absdiff_y(lane_r[k].ty, blob_r.centroid_y);
      // first blob of a frame reloads the best distances before the compare
      bdx_cur = blob_r.first_blob ? dx : lane_r[k].bdx;
      bdy_cur = blob_r.first_blob ? dy : lane_r[k].bdy;
      take = big && (bdx_cur >= dx || bdy_cur >= dy) &&
             dx < gate_x_r && dy < gate_y_r;

      lane_nxt[k].bdx = (take || blob_r.first_blob) ? dx : lane_r[k].bdx;
      lane_nxt[k].bdy = (take || blob_r.first_blob) ? dy : lane_r[k].bdy;
      lane_nxt[k].cx  = take ? blob_r.centroid_x : lane_r[k].cx;
      lane_nxt[k].cy  = take ? blob_r.centroid_y : lane_r[k].cy;

      // end of frame: each axis follows its candidate unless it jumps too far
      jx = lbt_pkg::absdiff_x(lane_nxt[k].cx, lane_r[k].tx);
      jy = lbt_pkg::absdiff_y(lane_nxt[k].cy, lane_r[k].ty);
      lane_nxt[k].tx = (blob_r.last_blob && jx <= jump_x_r) ? lane_nxt[k].cx
                                                            : lane_r[k].tx;
      lane_nxt[k].ty = (blob_r.last_blob && jy <= jump_y_r) ? lane_nxt[k].cy
                                                            : lane_r[k].ty;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lane_r[k] <= lbt_pkg::lane_init((k == lbt_pkg::LANE_LEFT) ? lbt_pkg::LEFT_X0
                                                                  : lbt_pkg::RIGHT_X0);
      end else if (blob_go) begin
        lane_r[k] <= lane_nxt[k];
      end
    end
  end

  // ---------------- output register ----------------
  logic [lbt_pkg::EW-1:0] steer_nxt;

  // modulo 2^16, matches the wrap of the 16-bit field
  assign steer_nxt = {1'b0, center_x_r, 1'b0}
                   - lbt_pkg::EW'(lane_nxt[lbt_pkg::LANE_LEFT].tx)
                   - lbt_pkg::EW'(lane_nxt[lbt_pkg::LANE_RIGHT].tx);

  logic [lbt_pkg::XW-1:0] left_x_r, right_x_r;
  logic [lbt_pkg::YW-1:0] left_y_r, right_y_r;
  logic [lbt_pkg::EW-1:0] steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= blob_go && blob_r.last_blob;
    end
  end

  always_ff @(posedge clk) begin
    if (blob_go && blob_r.last_blob) begin
      left_x_r  <= lane_nxt[lbt_pkg::LANE_LEFT].tx;
      left_y_r  <= lane_nxt[lbt_pkg::LANE_LEFT].ty;
      right_x_r <= lane_nxt[lbt_pkg::LANE_RIGHT].tx;
      right_y_r <= lane_nxt[lbt_pkg::LANE_RIGHT].ty;
      steer_r   <= steer_nxt;
    end
  end

  assign out_trk.valid       = out_vld_r;
  assign out_trk.left_x      = left_x_r;
  assign out_trk.left_y      = left_y_r;
  assign out_trk.right_x     = right_x_r;
  assign out_trk.right_y     = right_y_r;
  assign out_trk.steer_error = steer_r;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for lane_blob_tracker. Streams framed blobs and
// tracks both lanes in a local model. Depends on lbt_pkg, lbt_in_if, lbt_out_if.
module tb_top;
  import lbt_pkg::*;

  // Run bounds
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int DRAIN_CYCLES   = 4;    // input and output registers plus margin
  localparam int RANDOM_PHASES  = 8;

  // Writes to these indexes must be dropped by the block
  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {RDY_OPEN, RDY_RANDOM, RDY_COMB} ready_mode_e;

  // One lane as the model sees it: track, candidate, best distances
  typedef struct packed {
    logic [XW-1:0] tx;
    logic [YW-1:0] ty;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [XW-1:0] bdx;
    logic [YW-1:0] bdy;
  } lane_track_t;

  typedef struct packed {
    logic [XW-1:0] left_x;
    logic [YW-1:0] left_y;
    logic [XW-1:0] right_x;
    logic [YW-1:0] right_y;
    logic [EW-1:0] steer_error;
  } track_beat_t;

  // Clock and reset; every block input has a known value from time zero
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              blob_valid = 1'b0;
  blob_t             blob_drv   = '0;
  logic              trk_ready  = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CFG_IW-1:0] cfg_index  = '0;
  logic [CFG_DW-1:0] cfg_data   = '0;

  lbt_in_if  in_blob ();
  lbt_out_if out_trk ();

  assign in_blob.valid      = blob_valid;
  assign in_blob.centroid_x = blob_drv.centroid_x;
  assign in_blob.centroid_y = blob_drv.centroid_y;
  assign in_blob.area       = blob_drv.area;
  assign in_blob.first_blob = blob_drv.first_blob;
  assign in_blob.last_blob  = blob_drv.last_blob;
  assign out_trk.ready      = trk_ready;

  lane_blob_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_blob   (in_blob),
    .out_trk   (out_trk),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the register file, loaded with the reset values
  logic [AW-1:0] min_area_q = MIN_AREA_RST;
  logic [XW-1:0] gate_x_q   = GATE_X_RST;
  logic [YW-1:0] gate_y_q   = GATE_Y_RST;
  logic [XW-1:0] jump_x_q   = JUMP_X_RST;
  logic [YW-1:0] jump_y_q   = JUMP_Y_RST;
  logic [XW-1:0] center_x_q = LEFT_X0;

  lane_track_t lanes_q [NUM_LANES];

  blob_t       blob_queue[$];       // blobs waiting for the driver
  track_beat_t expected_tracks[$];  // track beats owed by the block

  int error_count   = 0;
  int blobs_sent    = 0;
  int tracks_seen   = 0;
  int settings_used = 1;
  int cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // Lane model
  // ---------------------------------------------------------------------------

  function automatic logic [XW-1:0] span_x(logic [XW-1:0] a, logic [XW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [YW-1:0] span_y(logic [YW-1:0] a, logic [YW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Candidate search for one lane. A first blob reloads the best distances
  // before it is judged, so it always wins the closeness test.
  function automatic void lane_observe(int k, blob_t b, bit big);
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    dx = span_x(lanes_q[k].tx, b.centroid_x);
    dy = span_y(lanes_q[k].ty, b.centroid_y);
    if (b.first_blob) begin
      lanes_q[k].bdx = dx;
      lanes_q[k].bdy = dy;
    end
    if (big && (lanes_q[k].bdx >= dx || lanes_q[k].bdy >= dy) &&
        dx < gate_x_q && dy < gate_y_q) begin
      lanes_q[k].bdx = dx;
      lanes_q[k].bdy = dy;
      lanes_q[k].cx  = b.centroid_x;
      lanes_q[k].cy  = b.centroid_y;
    end
  endfunction

  // End of frame: each axis follows its candidate unless the jump is too big
  function automatic void lane_commit(int k);
    if (span_x(lanes_q[k].cx, lanes_q[k].tx) <= jump_x_q) lanes_q[k].tx = lanes_q[k].cx;
    if (span_y(lanes_q[k].cy, lanes_q[k].ty) <= jump_y_q) lanes_q[k].ty = lanes_q[k].cy;
  endfunction

  function automatic void track_blob(blob_t b);
    track_beat_t r;
    bit          big;
    big = b.area > min_area_q;
    for (int k = 0; k < NUM_LANES; k++) lane_observe(k, b, big);
    if (!b.last_blob) return;
    for (int k = 0; k < NUM_LANES; k++) lane_commit(k);
    r.left_x      = lanes_q[LANE_LEFT].tx;
    r.left_y      = lanes_q[LANE_LEFT].ty;
    r.right_x     = lanes_q[LANE_RIGHT].tx;
    r.right_y     = lanes_q[LANE_RIGHT].ty;
    // wraps on 16 bits like the hardware
    r.steer_error = EW'({center_x_q, 1'b0}) - EW'(lanes_q[LANE_LEFT].tx)
                    - EW'(lanes_q[LANE_RIGHT].tx);
    expected_tracks.push_back(r);
  endfunction

  function automatic void check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps in between. The model runs
  // on the beat at the edge it is taken, so it sees blobs in stream order.
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    blob_t nxt;
    if (!rst_n) begin
      blob_valid <= 1'b0;
    end else if (!blob_valid || in_blob.ready) begin
      if (blob_valid) begin
        track_blob(blob_drv);
        blobs_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        blob_valid <= 1'b0;
      end else if (blob_queue.size() > 0) begin
        nxt = blob_queue.pop_front();
        blob_drv   <= nxt;
        blob_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a quarter of the bursts run straight into the next one
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        blob_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches between open, random and a fixed comb
  // ---------------------------------------------------------------------------

  ready_mode_e ready_mode = RDY_OPEN;
  int          mode_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      trk_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        RDY_OPEN:   trk_ready <= 1'b1;
        RDY_RANDOM: trk_ready <= ($urandom_range(0, 3) != 0);
        default:    trk_ready <= ((cycle_count % 11) < 6);  // fixed comb of open and stalled stretches
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each track beat against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    track_beat_t want;
    if (rst_n && out_trk.valid && out_trk.ready) begin
      tracks_seen++;
      if (expected_tracks.size() == 0) begin
        $error("track beat with nothing expected: left_x %0d right_x %0d",
               out_trk.left_x, out_trk.right_x);
        error_count++;
      end else begin
        want = expected_tracks.pop_front();
        check_field("left_x",  want.left_x,  out_trk.left_x);
        check_field("left_y",  want.left_y,  out_trk.left_y);
        check_field("right_x", want.right_x, out_trk.right_x);
        check_field("right_y", want.right_y, out_trk.right_y);
        check_field("steer_error", int'($signed(want.steer_error)),
                    int'(out_trk.steer_error));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d track beats still owed",
               cycle_count, expected_tracks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_blob(int x, int y, int a, bit f, bit l);
    blob_t b;
    b.centroid_x = XW'(x);
    b.centroid_y = YW'(y);
    b.area       = AW'(a);
    b.first_blob = f;
    b.last_blob  = l;
    blob_queue.push_back(b);
  endtask

  // Writes hold cfg_we high on back-to-back edges and drop it once at the end
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MIN_AREA: min_area_q = data[AW-1:0];
      REG_GATE_X:   gate_x_q   = data[XW-1:0];
      REG_GATE_Y:   gate_y_q   = data[YW-1:0];
      REG_JUMP_X:   jump_x_q   = data[XW-1:0];
      REG_JUMP_Y:   jump_y_q   = data[YW-1:0];
      REG_CENTER_X: center_x_q = data[XW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int ma, int gx, int gy, int jx, int jy, int cx);
    write_reg(REG_MIN_AREA, CFG_DW'(ma));
    write_reg(REG_GATE_X,   CFG_DW'(gx));
    write_reg(REG_GATE_Y,   CFG_DW'(gy));
    write_reg(REG_JUMP_X,   CFG_DW'(jx));
    write_reg(REG_JUMP_Y,   CFG_DW'(jy));
    write_reg(REG_CENTER_X, CFG_DW'(cx));
    // junk to an unused index, must not disturb anything
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
              CFG_DW'($urandom_range(0, 65535)));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random register pick: mostly typical, sometimes a range end or all ones
  function automatic int pick_reg(int hi, int typ_lo, int typ_hi);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return hi;
      2:       return 65535;  // masked to width by the block
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  function automatic int pick_area();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, min_area_q);   // not above the floor
      1:       return min_area_q + 1;                  // just above
      2:       return $urandom_range(0, 65535);
      default: return min_area_q + $urandom_range(1, 4000);
    endcase
  endfunction

  // Mostly well-formed frames of blobs scattered around both lanes; the rest
  // are empty frames, frames missing the first mark and loose noise beats.
  task automatic add_frames(int n_items);
    int  left_n;
    int  n;
    int  side;
    int  jx;
    int  jy;
    bit  no_first;
    left_n = n_items;
    while (left_n > 0) begin
      case ($urandom_range(0, 9))
        0: begin
          add_blob($urandom_range(0, 16383), $urandom_range(0, 2047), 0, 1'b1, 1'b1);
          left_n--;
        end
        1: begin
          add_blob($urandom_range(0, 16383), $urandom_range(0, 2047),
                   $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1));
          left_n--;
        end
        default: begin
          n = $urandom_range(1, 6);
          if (n > left_n) n = left_n;
          no_first = ($urandom_range(0, 7) == 0);
          jx = gate_x_q + 400;
          jy = gate_y_q + 100;
          for (int i = 0; i < n; i++) begin
            side = $urandom_range(0, NUM_LANES - 1);
            add_blob(int'(lanes_q[side].tx) + $urandom_range(0, 2 * jx) - jx,
                     int'(lanes_q[side].ty) + $urandom_range(0, 2 * jy) - jy,
                     pick_area(), (i == 0) && !no_first, i == n - 1);
          end
          left_n -= n;
        end
      endcase
    end
  endtask

  // Idle means: nothing queued, nothing on the wire, nothing owed, then the
  // pipeline depth again for blobs that carry no result
  task automatic drain_pipeline();
    while (blob_queue.size() != 0 || blob_valid || expected_tracks.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    lanes_q[LANE_LEFT]  = '{tx: LEFT_X0, ty: ROW_Y0, cx: LEFT_X0, cy: ROW_Y0,
                            bdx: '0, bdy: '0};
    lanes_q[LANE_RIGHT] = '{tx: RIGHT_X0, ty: ROW_Y0, cx: RIGHT_X0, cy: ROW_Y0,
                            bdx: '0, bdy: '0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values. Tracks start at (5120,720)/(7200,720).
    add_blob(0, 0, 0, 1'b1, 1'b1);                  // empty frame, centroid and area low
    add_blob(16383, 2047, 65535, 1'b1, 1'b0);       // centroid and area high, far off
    add_blob(5300, 700, 500, 1'b0, 1'b0);           // close to the left line
    add_blob(7150, 760, 300, 1'b0, 1'b1);           // close to the right, ends frame
    add_blob(5000, 720, 1000, 1'b1, 1'b1);          // first and last in one beat
    add_blob(5120, 720, 100, 1'b1, 1'b1);           // area equal to floor: ignored
    add_blob(5180, 730, 101, 1'b1, 1'b1);           // one above the floor
    add_blob(5180 + 2400, 730, 900, 1'b1, 1'b1);    // on the x gate edge of left
    add_blob(5180 + 2399, 730, 900, 1'b1, 1'b1);    // just inside it
    add_blob(5150, 710, 400, 1'b0, 1'b0);           // frame with no first mark
    add_blob(7300, 700, 400, 1'b0, 1'b0);
    add_blob(6200, 715, 400, 1'b0, 1'b1);
    add_blob(5000, 600, 2000, 1'b1, 1'b0);          // several blobs per lane
    add_blob(4900, 620, 2000, 1'b0, 1'b0);
    add_blob(7500, 800, 50, 1'b0, 1'b0);
    add_blob(7100, 700, 5000, 1'b0, 1'b1);
    add_blob(5100, 720 + 799, 300, 1'b1, 1'b1);     // y gate edges
    add_blob(5100, 720 + 800, 300, 1'b1, 1'b1);
    add_blob(8191, 1023, 32767, 1'b1, 1'b0);        // bit boundaries
    add_blob(8192, 1024, 32768, 1'b0, 1'b1);
    drain_pipeline();

    // Upper range ends: gates as wide as the image, any jump is taken
    program_regs(0, 10240, 1440, 10240, 1440, 10239);
    add_frames(40);
    drain_pipeline();

    // Lower ends: gates closed, jumps frozen, floor at the top of the range
    program_regs(57600, 0, 0, 0, 0, 0);
    add_frames(30);
    drain_pipeline();

    // All ones on every register, cut to width by the block
    program_regs(65535, 65535, 65535, 65535, 65535, 65535);
    add_frames(30);
    drain_pipeline();

    // Tight jump limits with open gates: candidates held back by the jump
    program_regs(50, 6000, 1200, 300, 100, 5120);
    add_frames(40);
    drain_pipeline();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_regs(pick_reg(57600, 0, 2000), pick_reg(10240, 200, 6000),
                   pick_reg(1440, 50, 1200), pick_reg(10240, 100, 6000),
                   pick_reg(1440, 20, 1200), pick_reg(10239, 0, 10239));
      add_frames(60);
      drain_pipeline();
    end

    repeat (8) @(posedge clk);
    if (expected_tracks.size() != 0) begin
      $error("%0d track beats never arrived", expected_tracks.size());
      error_count++;
    end
    $display("Ran %0d blob beats and checked %0d track beats under %0d register settings",
             blobs_sent, tracks_seen, settings_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lbt_pkg.sv
hdl/lbt_in_if.sv
hdl/lbt_out_if.sv
hdl/lane_blob_tracker.sv
bench/tb_top.sv
